// ----- sv/tfe_pkg.sv -----
// package for the telemetry frame encoder: payload structs, frame constants
// and the item type passed from the front end to the serializer
// no dependencies
`default_nettype none

package tfe_pkg;

   localparam int NUM_WORDS = 9;

   typedef struct packed {
      logic              mode;
      logic signed [23:0] value_0;
      logic signed [23:0] value_1;
      logic signed [23:0] value_2;
      logic signed [23:0] value_3;
      logic signed [23:0] value_4;
      logic signed [23:0] value_5;
      logic signed [23:0] value_6;
      logic signed [23:0] value_7;
      logic signed [23:0] value_8;
   } tfe_req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } tfe_rsp_type;

   // classified item: payload words already formed, unused words zero
   typedef struct packed {
      logic                        mode;
      logic [NUM_WORDS-1:0][15:0] words;
   } tfe_item_type;

   typedef logic [4:0] byte_idx_type;

   localparam logic [7:0]   SYNC_BYTE          = 8'hAA;
   localparam logic [7:0]   KIND_ATTITUDE      = 8'h01;
   localparam logic [7:0]   KIND_RAW           = 8'h02;
   localparam logic [7:0]   LEN_ATTITUDE       = 8'd10;
   localparam logic [7:0]   LEN_RAW            = 8'd18;
   localparam logic [30:0]  ANGLE_SCALE        = 31'd100;
   localparam logic [30:0]  ROUND_TO_ZERO      = 31'd255;
   localparam byte_idx_type IDX_SYNC_0         = 5'd0;
   localparam byte_idx_type IDX_SYNC_1         = 5'd1;
   localparam byte_idx_type IDX_KIND           = 5'd2;
   localparam byte_idx_type IDX_LEN            = 5'd3;
   localparam byte_idx_type IDX_PAYLOAD        = 5'd4;
   localparam byte_idx_type IDX_LAST_ATTITUDE  = 5'd14;
   localparam byte_idx_type IDX_LAST_RAW       = 5'd22;

endpackage

`default_nettype wire

// ----- sv/telemetry_frame_encoder_unit.sv -----
// Telemetry frame encoder, top level.
// Request channel (req_valid/req_ready/req_data) takes one transaction per
// frame: a mode bit and nine signed 24-bit values. Response channel
// (rsp_valid/rsp_ready/rsp_data) returns the frame one byte per
// transaction, last_byte set on the trailing checksum byte.
// Frame: AA AA kind len payload checksum; attitude frames are 15 bytes,
// raw sensor frames 23 bytes.
// A request reaches rsp_data through the fifo, item and output registers.
// Throughput: one byte per cycle from the serializer while rsp_ready is
// high; frames follow each other with no gap while requests are queued.
// The front end forms payload words in the request cycle and writes them
// into a QUEUE_DEPTH entry fifo; req_ready is low only while it is full.
// A stalled receiver holds the output register and the serializer; the
// fifo keeps taking requests until it fills.
// Reset (synchronous, active high) empties the fifo and drops rsp_valid.
// depends on tfe_pkg, tfe_front, tfe_queue, tfe_back
`default_nettype none

module telemetry_frame_encoder_unit import tfe_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire  logic        clock,
   input  wire  logic        reset,
   input  wire  logic        req_valid,
   output       logic        req_ready,
   input  wire  tfe_req_type req_data,
   output       logic        rsp_valid,
   input  wire  logic        rsp_ready,
   output       tfe_rsp_type rsp_data
);

   logic         push;
   logic         pop;
   logic         full;
   logic         empty;
   tfe_item_type push_item;
   tfe_item_type head;

   tfe_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (full),
      .push       (push),
      .push_item  (push_item)
   );

   tfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .head      (head)
   );

   tfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- sv/tfe_front.sv -----
// front end: accepts request transactions and forms the payload words
// (angle scaling for attitude frames, low halves for raw frames)
// depends on tfe_pkg
`default_nettype none

module tfe_front import tfe_pkg::*; (
   input  wire  logic         req_valid,
   output       logic         req_ready,
   input  wire  tfe_req_type  req_data,
   input  wire  logic         queue_full,
   output       logic         push,
   output       tfe_item_type push_item
);

   // value * 100 / 256, truncated toward zero, low 16 bits
   function automatic logic [15:0] angle_word(input logic signed [23:0] v);
      logic signed [30:0] prod;
      logic        [30:0] adj;
      prod = $signed({{7{v[23]}}, v}) * $signed(ANGLE_SCALE);
      adj  = prod + (prod[30] ? ROUND_TO_ZERO : 31'd0);
      return adj[23:8];
   endfunction

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_item.mode = req_data.mode;
      if (req_data.mode) begin
         push_item.words[0] = req_data.value_0[15:0];
         push_item.words[1] = req_data.value_1[15:0];
         push_item.words[2] = req_data.value_2[15:0];
         push_item.words[3] = req_data.value_3[15:0];
         push_item.words[4] = req_data.value_4[15:0];
         push_item.words[5] = req_data.value_5[15:0];
         push_item.words[6] = req_data.value_6[15:0];
         push_item.words[7] = req_data.value_7[15:0];
         push_item.words[8] = req_data.value_8[15:0];
      end else begin
         push_item.words[0] = angle_word(req_data.value_0);
         push_item.words[1] = angle_word(req_data.value_1);
         push_item.words[2] = angle_word(req_data.value_2);
         push_item.words[3] = 16'h0000;
         push_item.words[4] = 16'h0000;
         push_item.words[5] = 16'h0000;
         push_item.words[6] = 16'h0000;
         push_item.words[7] = 16'h0000;
         push_item.words[8] = 16'h0000;
      end
   end

endmodule

`default_nettype wire

// ----- sv/tfe_queue.sv -----
// small fifo of classified items between the front end and the serializer
// depends on tfe_pkg
`default_nettype none

module tfe_queue import tfe_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  wire  logic         clock,
   input  wire  logic         reset,
   input  wire  logic         push,
   input  wire  tfe_item_type push_item,
   output       logic         full,
   input  wire  logic         pop,
   output       logic         empty,
   output       tfe_item_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tfe_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ----- sv/tfe_back.sv -----
// back end: serializes one item per frame, one byte per cycle unless
// stalled, keeps running checksum, drives registered response channel
// depends on tfe_pkg
`default_nettype none

module tfe_back import tfe_pkg::*; (
   input  wire  logic         clock,
   input  wire  logic         reset,
   input  wire  logic         empty,
   input  wire  tfe_item_type head,
   output       logic         pop,
   output       logic         rsp_valid,
   input  wire  logic         rsp_ready,
   output       tfe_rsp_type  rsp_data
);

   logic         active_ff, active_in;
   tfe_item_type cur_ff, cur_in;
   byte_idx_type idx_ff, idx_in;
   logic [7:0]   sum_ff, sum_in;
   logic         rsp_valid_ff, rsp_valid_in;
   tfe_rsp_type  rsp_data_ff, rsp_data_in;

   logic         load_out;
   logic         is_last;
   byte_idx_type last_idx;
   byte_idx_type pay_off;
   logic [3:0]   word_sel;
   logic [15:0]  word;
   logic [7:0]   cur_byte;

   assign last_idx = cur_ff.mode ? IDX_LAST_RAW : IDX_LAST_ATTITUDE;
   assign is_last  = (idx_ff == last_idx);
   assign load_out = active_ff && (!rsp_valid_ff || rsp_ready);
   assign pop      = !empty && (!active_ff || (load_out && is_last));

   // payload bytes pair up into words, high byte on the even offset
   assign pay_off  = idx_ff - IDX_PAYLOAD;
   assign word_sel = pay_off[4:1];

   always_comb begin
      case (word_sel)
         4'd0:    word = cur_ff.words[0];
         4'd1:    word = cur_ff.words[1];
         4'd2:    word = cur_ff.words[2];
         4'd3:    word = cur_ff.words[3];
         4'd4:    word = cur_ff.words[4];
         4'd5:    word = cur_ff.words[5];
         4'd6:    word = cur_ff.words[6];
         4'd7:    word = cur_ff.words[7];
         4'd8:    word = cur_ff.words[8];
         default: word = 16'h0000;
      endcase
   end

   always_comb begin
      if (idx_ff == IDX_SYNC_0 || idx_ff == IDX_SYNC_1) begin
         cur_byte = SYNC_BYTE;
      end else if (idx_ff == IDX_KIND) begin
         cur_byte = cur_ff.mode ? KIND_RAW : KIND_ATTITUDE;
      end else if (idx_ff == IDX_LEN) begin
         cur_byte = cur_ff.mode ? LEN_RAW : LEN_ATTITUDE;
      end else if (is_last) begin
         cur_byte = sum_ff;
      end else begin
         cur_byte = pay_off[0] ? word[7:0] : word[15:8];
      end
   end

   always_comb begin
      active_in    = active_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.frame_byte = cur_byte;
         rsp_data_in.last_byte  = is_last;
         idx_in                 = idx_ff + 1'b1;
         sum_in                 = sum_ff + cur_byte;
         if (is_last) begin
            active_in = 1'b0;
         end
      end
      // next frame starts right behind the checksum byte
      if (pop) begin
         active_in = 1'b1;
         cur_in    = head;
         idx_in    = IDX_SYNC_0;
         sum_in    = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= IDX_SYNC_0;
         sum_ff       <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- sv/tfe_checker.sv -----
// port-level checks for the telemetry frame encoder, bound to the top level
// depends on tfe_pkg and telemetry_frame_encoder_unit
`default_nettype none

module tfe_checker import tfe_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire tfe_rsp_type rsp_data
);

   // a stalled response transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // after a checksum byte the next frame opens with a sync byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last_byte
      |=> !rsp_valid || rsp_data.frame_byte == SYNC_BYTE)
      else $error("frame does not start with sync byte");

   // the fifo is empty after reset, so a request is taken at once
   assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("request channel blocked after reset");

endmodule

bind telemetry_frame_encoder_unit tfe_checker u_tfe_checker (.*);

`default_nettype wire

// ----- tb/tb_telemetry_frame_encoder_unit.sv -----
`timescale 1ns / 100ps
// self-checking testbench for telemetry_frame_encoder_unit: predicts every
// frame byte and checks it against the response channel
// depends on tfe_pkg and the telemetry_frame_encoder_unit rtl

module tb_telemetry_frame_encoder_unit;
   import tfe_pkg::*;

   // expected frame bytes for accepted requests, checked in arrival order
   class frame_ledger;
      tfe_rsp_type expected_bytes[$];
      int          error_count = 0;
      int          bytes_seen = 0;
      int          attitude_frames = 0;
      int          raw_frames = 0;

      // degrees q15.8 times 100, truncated toward zero, wrapped to 16 bits
      function automatic logic [15:0] scaled_angle(logic [23:0] v);
         longint          prod;
         longint unsigned mag;
         longint unsigned q;
         prod = {{40{v[23]}}, v};
         prod = prod * 100;
         mag = (prod < 0) ? longint'(-prod) : prod;
         q = mag >> 8;
         if (prod < 0) begin
            q = -q;
         end
         return q[15:0];
      endfunction

      function void note_request(tfe_req_type r);
         logic [23:0] vals[9];
         logic [7:0]  frame[$];
         logic [7:0]  sum;
         logic [15:0] w;
         tfe_rsp_type item;
         vals[0] = r.value_0;
         vals[1] = r.value_1;
         vals[2] = r.value_2;
         vals[3] = r.value_3;
         vals[4] = r.value_4;
         vals[5] = r.value_5;
         vals[6] = r.value_6;
         vals[7] = r.value_7;
         vals[8] = r.value_8;
         frame.push_back(SYNC_BYTE);
         frame.push_back(SYNC_BYTE);
         if (r.mode) begin
            raw_frames++;
            frame.push_back(KIND_RAW);
            frame.push_back(LEN_RAW);
            for (int i = 0; i < 9; i++) begin
               w = vals[i][15:0];
               frame.push_back(w[15:8]);
               frame.push_back(w[7:0]);
            end
         end else begin
            attitude_frames++;
            frame.push_back(KIND_ATTITUDE);
            frame.push_back(LEN_ATTITUDE);
            // value_3..value_8 play no part here
            for (int i = 0; i < 3; i++) begin
               w = scaled_angle(vals[i]);
               frame.push_back(w[15:8]);
               frame.push_back(w[7:0]);
            end
            for (int i = 0; i < 4; i++) begin
               frame.push_back(8'h00);
            end
         end
         sum = 8'h00;
         foreach (frame[i]) begin
            sum = sum + frame[i];
         end
         frame.push_back(sum);
         foreach (frame[i]) begin
            item.frame_byte = frame[i];
            item.last_byte = (i == frame.size() - 1);
            expected_bytes.push_back(item);
         end
      endfunction

      function void check_byte(tfe_rsp_type got);
         tfe_rsp_type want;
         bytes_seen++;
         if (expected_bytes.size() == 0) begin
            $error("unexpected frame_byte %h last_byte %b", got.frame_byte, got.last_byte);
            error_count++;
            return;
         end
         want = expected_bytes.pop_front();
         if (got.frame_byte !== want.frame_byte) begin
            $error("frame_byte expected %h actual %h", want.frame_byte, got.frame_byte);
            error_count++;
         end
         if (got.last_byte !== want.last_byte) begin
            $error("last_byte expected %b actual %b", want.last_byte, got.last_byte);
            error_count++;
         end
      endfunction

      function int pending_count();
         return expected_bytes.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   tfe_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   tfe_rsp_type rsp_data;

   frame_ledger ledger = new();
   bit          steady = 1'b0;

   telemetry_frame_encoder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: check each accepted byte, then pick the next ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         ledger.check_byte(rsp_data);
      end
      rsp_ready <= steady || ($urandom_range(0, 99) >= 21);
   end

   task automatic send_request(input tfe_req_type item);
      if (!steady && $urandom_range(0, 99) < 21) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_data <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      ledger.note_request(item);
   endtask

   function automatic tfe_req_type build_request(bit mode, logic [23:0] a, logic [23:0] b,
                                                 logic [23:0] c, logic [23:0] fill);
      tfe_req_type r;
      r.mode = mode;
      r.value_0 = a;
      r.value_1 = b;
      r.value_2 = c;
      r.value_3 = fill;
      r.value_4 = ~fill;
      r.value_5 = fill;
      r.value_6 = ~fill;
      r.value_7 = fill;
      r.value_8 = ~fill;
      return r;
   endfunction

   function automatic logic [23:0] random_value();
      int v;
      case ($urandom_range(0, 5))
         3: begin
            v = $urandom_range(0, 511);
            v = v - 256;
         end
         4: begin
            case ($urandom_range(0, 3))
               0: v = 32'h007FFFFF;
               1: v = 32'hFF800000;
               2: v = 0;
               default: v = -1;
            endcase
         end
         // around the point where angle * 100 leaves 16 bits
         5: begin
            v = 83880 + $urandom_range(0, 12);
            if ($urandom_range(0, 1)) begin
               v = -v;
            end
         end
         default: v = $urandom;
      endcase
      return v[23:0];
   endfunction

   initial begin
      tfe_req_type r;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // attitude: zero, both extremes with overflow, truncation of small values
      send_request(build_request(1'b0, 24'h000000, 24'h000000, 24'h000000, 24'h000000));
      send_request(build_request(1'b0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h123456));
      send_request(build_request(1'b0, 24'h800000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF));
      send_request(build_request(1'b0, 24'hFFFFFF, 24'hFFFFFD, 24'h000003, 24'hA5A5A5));
      send_request(build_request(1'b0, 24'd83884, 24'd83886, -24'sd83886, 24'h5A5A5A));
      send_request(build_request(1'b0, 24'd256, -24'sd256, 24'd1280, 24'($urandom)));
      // raw: zero, all ones, extremes, alternating bits, upper bits dropped
      send_request(build_request(1'b1, 24'h000000, 24'h000000, 24'h000000, 24'h000000));
      send_request(build_request(1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
      send_request(build_request(1'b1, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000));
      send_request(build_request(1'b1, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA));
      send_request(build_request(1'b1, 24'h12ABCD, 24'hFF0001, 24'h00FFFF, 24'h7F8000));
      for (int i = 0; i < 6; i++) begin
         send_request(build_request(i[0], 24'($urandom), 24'($urandom), 24'($urandom),
                                    24'($urandom)));
      end

      for (int n = 0; n < 93; n++) begin
         steady = (n >= 40 && n < 65);
         r.mode = 1'($urandom_range(0, 1));
         r.value_0 = random_value();
         r.value_1 = random_value();
         r.value_2 = random_value();
         r.value_3 = random_value();
         r.value_4 = random_value();
         r.value_5 = random_value();
         r.value_6 = random_value();
         r.value_7 = random_value();
         r.value_8 = random_value();
         send_request(r);
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      while (ledger.pending_count() != 0) @(posedge clock);
      // any trailing byte after this point shows up as unexpected
      repeat (30) @(posedge clock);

      $display("frames: %0d attitude, %0d raw; %0d bytes checked",
               ledger.attitude_frames, ledger.raw_frames, ledger.bytes_seen);
      if (ledger.error_count == 0 && ledger.pending_count() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d bytes still owed", ledger.error_count,
                  ledger.pending_count());
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d bytes still owed", ledger.pending_count());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
